// ----- rtl/core/fcma_pkg.sv -----
// ----------------------------------------------------------------------------
// fcma_pkg: shared types and constants of the four-channel moving average
// Sizes of the frame ring, running sums and the shared divider.
// ----------------------------------------------------------------------------
package fcma_pkg;

	// frame ring and sample format
	localparam int DEPTH       = 128;
	localparam int SAMPLE_BITS = 24;
	localparam int NCH         = 4;
	localparam int FRAME_BITS  = NCH * SAMPLE_BITS;
	localparam int ADDR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// window length register and effective length
	localparam int WL_BITS  = 8;
	localparam int LEN_BITS = ($clog2(DEPTH + 1) > WL_BITS) ? $clog2(DEPTH + 1) : WL_BITS;
	localparam logic [WL_BITS-1:0] WINDOW_RESET = WL_BITS'(100);

	// running sum grows by the ring address bits
	localparam int SUM_BITS = SAMPLE_BITS + ADDR_BITS;

	// divider: four quotient bits per cycle
	localparam int RADIX_BITS = 4;
	localparam int DIV_BITS   = ((SUM_BITS + RADIX_BITS - 1) / RADIX_BITS) * RADIX_BITS;
	localparam int DIV_STEPS  = DIV_BITS / RADIX_BITS;
	localparam int CNT_BITS   = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
	localparam int CH_BITS    = $clog2(NCH);

	// configuration port
	localparam int CFG_ADDR_BITS = 3;
	localparam int CFG_DATA_BITS = 32;
	localparam logic REG_WINDOW_LEN = 1'b0;

	// divider request and response
	typedef struct packed {
		logic                start;
		logic [DIV_BITS-1:0] dividend;
		logic [LEN_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [DIV_BITS-1:0] quotient;
	} div_rsp_t;

	// sequencer states
	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_UPD    = 5'b00010,
		S_DSTART = 5'b00100,
		S_DWAIT  = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

endpackage

// ----- rtl/core/fcma_ram.sv -----
// ----------------------------------------------------------------------------
// fcma_ram: generic simple dual-port ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fcma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                          wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                          rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ----- rtl/core/fcma_div.sv -----
// ----------------------------------------------------------------------------
// fcma_div: shared unsigned restoring divider
// Divides a magnitude by the window length, four quotient bits per cycle.
// ----------------------------------------------------------------------------
module fcma_div (
	input  logic               clk,
	input  logic               arst_n,
	input  fcma_pkg::div_req_t req,
	output fcma_pkg::div_rsp_t rsp
);

	logic [fcma_pkg::DIV_BITS-1:0] quo_q;
	logic [fcma_pkg::LEN_BITS-1:0] rem_q;
	logic [fcma_pkg::LEN_BITS-1:0] divs_q;
	logic [fcma_pkg::CNT_BITS-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [fcma_pkg::DIV_BITS-1:0] quo_nx;
	logic [fcma_pkg::LEN_BITS-1:0] rem_nx;

	// four shift-subtract steps per cycle
	always_comb begin
		logic [fcma_pkg::LEN_BITS:0]   r;
		logic [fcma_pkg::DIV_BITS-1:0] q;
		r = '0;
		q = quo_q;
		rem_nx = rem_q;
		for (int i = 0; i < fcma_pkg::RADIX_BITS; i++) begin
			r = {rem_nx, q[fcma_pkg::DIV_BITS-1]};
			q = {q[fcma_pkg::DIV_BITS-2:0], 1'b0};
			if (r >= {1'b0, divs_q}) begin
				r = r - {1'b0, divs_q};
				q[0] = 1'b1;
			end
			rem_nx = r[fcma_pkg::LEN_BITS-1:0];
		end
		quo_nx = q;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == fcma_pkg::CNT_BITS'(fcma_pkg::DIV_STEPS - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == fcma_pkg::CNT_BITS'(fcma_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q  <= req.dividend;
			rem_q  <= '0;
			divs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= quo_nx;
			rem_q <= rem_nx;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ----- rtl/core/four_channel_moving_average_top.sv -----
// ----------------------------------------------------------------------------
// four_channel_moving_average_top: boxcar average of four sensor channels
// A frame that fills the window gives its means once four passes of the shared
// divider (one per channel) are done, with the input ready again in the cycle the
// means appear on the output; a frame with no result passes through a ring read,
// then a sum update and ring write.
// Asynchronous reset empties the window and sets window_len to 100.
// ----------------------------------------------------------------------------
module four_channel_moving_average_top (
	input  logic                               clk,
	input  logic                               arst_n,
	// input frames
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// pressure_in, temperature_in, sound_in, light_in (24 bits each)
	input  logic [fcma_pkg::FRAME_BITS-1:0]    s_tdata,
	// result frames
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// pressure_mean, temperature_mean, sound_mean, light_mean (24 bits each)
	output logic [fcma_pkg::FRAME_BITS-1:0]    m_tdata,
	// configuration
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [fcma_pkg::CFG_ADDR_BITS-1:0] paddr,
	input  logic [fcma_pkg::CFG_DATA_BITS-1:0] pwdata,
	output logic [fcma_pkg::CFG_DATA_BITS-1:0] prdata,
	output logic                               pready
);

	localparam int SB = fcma_pkg::SAMPLE_BITS;
	localparam int PAD = fcma_pkg::DIV_BITS - fcma_pkg::SUM_BITS;

	fcma_pkg::state_t              state_q;
	logic [fcma_pkg::WL_BITS-1:0]  window_len_q;
	logic [fcma_pkg::SUM_BITS-1:0] sum_q [fcma_pkg::NCH];
	logic [fcma_pkg::LEN_BITS-1:0] fill_q;
	logic [fcma_pkg::ADDR_BITS-1:0] write_slot_q;
	logic [fcma_pkg::ADDR_BITS-1:0] slot_q;
	logic                          full_q;
	logic [fcma_pkg::FRAME_BITS-1:0] in_q;
	logic [SB-1:0]                 mean_q [fcma_pkg::NCH];
	logic [fcma_pkg::CH_BITS-1:0]  ch_q;
	logic                          out_valid_q;
	logic [fcma_pkg::FRAME_BITS-1:0] out_data_q;

	logic                          cfg_wr;
	logic [fcma_pkg::LEN_BITS-1:0] len_eff;
	logic [fcma_pkg::ADDR_BITS-1:0] slot_sel;
	logic [fcma_pkg::LEN_BITS-1:0] slot_inc;
	logic [fcma_pkg::LEN_BITS-1:0] fill_nx;
	logic [fcma_pkg::SUM_BITS-1:0] sum_nx [fcma_pkg::NCH];
	logic [fcma_pkg::FRAME_BITS-1:0] rd_data;
	logic [fcma_pkg::SUM_BITS-1:0] sum_sel;
	logic                          sum_neg;
	logic [fcma_pkg::DIV_BITS-1:0] sum_ext;
	logic [SB-1:0]                 q_low;
	logic [SB-1:0]                 mean_nx;
	logic                          in_xfer;
	logic                          out_load;
	fcma_pkg::div_req_t            div_req;
	fcma_pkg::div_rsp_t            div_rsp;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready &&
		(paddr[fcma_pkg::CFG_ADDR_BITS-1:2] == fcma_pkg::REG_WINDOW_LEN);
	always_comb begin
		prdata = '0;
		if (paddr[fcma_pkg::CFG_ADDR_BITS-1:2] == fcma_pkg::REG_WINDOW_LEN) begin
			prdata = fcma_pkg::CFG_DATA_BITS'(window_len_q);
		end
	end

	// effective window length and ring slot
	always_comb begin
		if (window_len_q == '0) begin
			len_eff = fcma_pkg::LEN_BITS'(1);
		end else if (fcma_pkg::LEN_BITS'(window_len_q) > fcma_pkg::LEN_BITS'(fcma_pkg::DEPTH)) begin
			len_eff = fcma_pkg::LEN_BITS'(fcma_pkg::DEPTH);
		end else begin
			len_eff = fcma_pkg::LEN_BITS'(window_len_q);
		end
		slot_sel = (fcma_pkg::LEN_BITS'(write_slot_q) >= len_eff) ? '0 : write_slot_q;
		slot_inc = fcma_pkg::LEN_BITS'(slot_q) + 1'b1;
		fill_nx  = full_q ? fill_q : fill_q + 1'b1;
	end

	// running sum update: drop oldest when full, add newest
	always_comb begin
		for (int c = 0; c < fcma_pkg::NCH; c++) begin
			logic [SB-1:0] old_s;
			logic [SB-1:0] new_s;
			old_s = full_q ? rd_data[c*SB +: SB] : '0;
			new_s = in_q[c*SB +: SB];
			sum_nx[c] = sum_q[c]
				- {{fcma_pkg::ADDR_BITS{old_s[SB-1]}}, old_s}
				+ {{fcma_pkg::ADDR_BITS{new_s[SB-1]}}, new_s};
		end
	end

	// divider operand and signed mean
	assign sum_sel = sum_q[ch_q];
	assign sum_neg = sum_sel[fcma_pkg::SUM_BITS-1];
	assign sum_ext = {{PAD{sum_sel[fcma_pkg::SUM_BITS-1]}}, sum_sel};
	assign q_low   = div_rsp.quotient[SB-1:0];
	assign mean_nx = sum_neg ? (~q_low + 1'b1) : q_low;

	assign div_req.start    = (state_q == fcma_pkg::S_DSTART);
	assign div_req.dividend = sum_neg ? (~sum_ext + 1'b1) : sum_ext;
	assign div_req.divisor  = len_eff;

	fcma_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// frame ring
	fcma_ram #(
		.WIDTH (fcma_pkg::FRAME_BITS),
		.DEPTH (fcma_pkg::DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (state_q == fcma_pkg::S_UPD),
		.wr_addr (slot_q),
		.wr_data (in_q),
		.rd_addr (slot_sel),
		.rd_data (rd_data)
	);

	// handshakes
	assign s_tready = (state_q == fcma_pkg::S_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign out_load = (state_q == fcma_pkg::S_DONE) && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// sequencer and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= fcma_pkg::S_IDLE;
			window_len_q <= fcma_pkg::WINDOW_RESET;
			fill_q       <= '0;
			write_slot_q <= '0;
			ch_q         <= '0;
			out_valid_q  <= 1'b0;
			for (int c = 0; c < fcma_pkg::NCH; c++) begin
				sum_q[c] <= '0;
			end
		end else begin
			// output register
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				fcma_pkg::S_IDLE: begin
					if (in_xfer) begin
						state_q <= fcma_pkg::S_UPD;
					end
				end
				fcma_pkg::S_UPD: begin
					for (int c = 0; c < fcma_pkg::NCH; c++) begin
						sum_q[c] <= sum_nx[c];
					end
					fill_q       <= fill_nx;
					write_slot_q <= (slot_inc >= len_eff) ? '0 :
						slot_inc[fcma_pkg::ADDR_BITS-1:0];
					ch_q         <= '0;
					state_q      <= (fill_nx >= len_eff) ? fcma_pkg::S_DSTART : fcma_pkg::S_IDLE;
				end
				fcma_pkg::S_DSTART: begin
					state_q <= fcma_pkg::S_DWAIT;
				end
				fcma_pkg::S_DWAIT: begin
					if (div_rsp.done) begin
						if (ch_q == fcma_pkg::CH_BITS'(fcma_pkg::NCH - 1)) begin
							state_q <= fcma_pkg::S_DONE;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= fcma_pkg::S_DSTART;
						end
					end
				end
				fcma_pkg::S_DONE: begin
					if (out_load) begin
						state_q <= fcma_pkg::S_IDLE;
					end
				end
				default: state_q <= fcma_pkg::S_IDLE;
			endcase

			// window_len write empties the window
			if (cfg_wr) begin
				window_len_q <= pwdata[fcma_pkg::WL_BITS-1:0];
				fill_q       <= '0;
				write_slot_q <= '0;
				for (int c = 0; c < fcma_pkg::NCH; c++) begin
					sum_q[c] <= '0;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			in_q   <= s_tdata;
			slot_q <= slot_sel;
			full_q <= (fill_q >= len_eff);
		end
		if ((state_q == fcma_pkg::S_DWAIT) && div_rsp.done) begin
			mean_q[ch_q] <= mean_nx;
		end
		if (out_load) begin
			for (int c = 0; c < fcma_pkg::NCH; c++) begin
				out_data_q[c*SB +: SB] <= mean_q[c];
			end
		end
	end

`ifndef SYNTHESIS
	// the fill count never exceeds the ring depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= fcma_pkg::LEN_BITS'(fcma_pkg::DEPTH))
		else $error("fill count above ring depth");

	// the next ring slot always lies inside the window
	a_slot_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		fcma_pkg::LEN_BITS'(write_slot_q) < len_eff)
		else $error("write slot outside window");

	// the divider finishes only while the sequencer waits for it
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == fcma_pkg::S_DWAIT))
		else $error("divider done outside wait state");
`endif

endmodule
